// ----- rtl/assert_macros.svh -----
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge, held off during reset.
`define ASSERT_CLK(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Implication checked on every rising clock edge, including during reset.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ----- rtl/v2cos_pkg.sv -----
`default_nettype none
package v2cos_pkg;
    localparam int COMP_WIDTH = 16;
    localparam int FRAC_BITS  = 14;
    localparam int COS_WIDTH  = FRAC_BITS + 2;
    localparam int SQ_WIDTH   = 2 * COMP_WIDTH + 1;
    localparam int DOT_WIDTH  = 2 * COMP_WIDTH + 1;
    localparam int PQ_WIDTH   = 2 * SQ_WIDTH;
    localparam int ROOT_WIDTH = SQ_WIDTH;
    localparam int DIN_WIDTH  = 4 * COMP_WIDTH;
    localparam int DOUT_WIDTH = ((COS_WIDTH + 7) / 8) * 8;

    // Per-item sideband carried alongside the arithmetic.
    typedef struct packed {
        logic zero;
        logic neg;
        logic sat;
    } side_t;
endpackage
`default_nettype wire

// ----- rtl/v2cos_sqrt.sv -----
`default_nettype none
// Pipelined restoring square root of a PQ_WIDTH-bit value, one root bit per
// stage. The dot-product magnitude and sideband ride along with each item.
module v2cos_sqrt (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [v2cos_pkg::PQ_WIDTH-1:0]      in_rad,
    input  wire logic [v2cos_pkg::DOT_WIDTH-1:0]     in_adot,
    input  wire v2cos_pkg::side_t                    in_side,
    output logic                                     out_valid,
    output logic [v2cos_pkg::ROOT_WIDTH-1:0]         out_root,
    output logic [v2cos_pkg::DOT_WIDTH-1:0]          out_adot,
    output v2cos_pkg::side_t                         out_side
);
    localparam int N  = v2cos_pkg::ROOT_WIDTH;
    localparam int RW = v2cos_pkg::ROOT_WIDTH + 2;

    logic [N:0]                           valid_reg;
    logic [v2cos_pkg::PQ_WIDTH-1:0]       rad_reg  [N+1];
    logic [RW-1:0]                        rem_reg  [N+1];
    logic [N-1:0]                         root_reg [N+1];
    logic [v2cos_pkg::DOT_WIDTH-1:0]      adot_reg [N+1];
    v2cos_pkg::side_t                     side_reg [N+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[N-1:0], in_valid};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rad_reg[0]  <= in_rad;
            rem_reg[0]  <= '0;
            root_reg[0] <= '0;
            adot_reg[0] <= in_adot;
            side_reg[0] <= in_side;
        end
    end

    for (genvar k = 0; k < N; k++) begin : g_step
        logic [RW-1:0] trial;
        logic [RW-1:0] shifted;
        always_comb begin
            shifted = {rem_reg[k][RW-3:0], rad_reg[k][v2cos_pkg::PQ_WIDTH-1 -: 2]};
            trial   = {root_reg[k], 2'b01};
        end
        always_ff @(posedge aclk) begin
            if (en) begin
                rad_reg[k+1]  <= {rad_reg[k][v2cos_pkg::PQ_WIDTH-3:0], 2'b00};
                adot_reg[k+1] <= adot_reg[k];
                side_reg[k+1] <= side_reg[k];
                if (shifted >= trial) begin
                    rem_reg[k+1]  <= shifted - trial;
                    root_reg[k+1] <= {root_reg[k][N-2:0], 1'b1};
                end else begin
                    rem_reg[k+1]  <= shifted;
                    root_reg[k+1] <= {root_reg[k][N-2:0], 1'b0};
                end
            end
        end
    end

    assign out_valid = valid_reg[N];
    assign out_root  = root_reg[N];
    assign out_adot  = adot_reg[N];
    assign out_side  = side_reg[N];
endmodule
`default_nettype wire

// ----- rtl/v2cos_div.sv -----
`default_nettype none
// Pipelined restoring divider: adot * 2^FRAC_BITS / root, one quotient bit
// per stage, with saturation and sign applied at the end.
module v2cos_div (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                en,
    input  wire logic                                in_valid,
    input  wire logic [v2cos_pkg::ROOT_WIDTH-1:0]    in_root,
    input  wire logic [v2cos_pkg::DOT_WIDTH-1:0]     in_adot,
    input  wire v2cos_pkg::side_t                    in_side,
    output logic                                     out_valid,
    output logic [v2cos_pkg::COS_WIDTH-1:0]          out_cos,
    output logic                                     out_zero
);
    localparam int F  = v2cos_pkg::FRAC_BITS;
    localparam int W  = v2cos_pkg::ROOT_WIDTH + 1;
    localparam int CW = v2cos_pkg::COS_WIDTH;

    logic [F+1:0]                         valid_reg;
    logic [W-1:0]                         div_reg [F+1];
    logic [W-1:0]                         rem_reg [F+1];
    logic [F-1:0]                         quo_reg [F+1];
    v2cos_pkg::side_t                     side_reg [F+1];
    logic [CW-1:0]                        cos_reg;
    logic                                 zero_reg;

    logic [v2cos_pkg::ROOT_WIDTH-1:0] root_fix;
    always_comb begin
        root_fix = (in_root == '0) ? v2cos_pkg::ROOT_WIDTH'(1) : in_root;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[F:0], in_valid};
        end
    end

    // The remainder starts at adot, which stays below the divisor unless the
    // item saturates; a saturating item keeps its flag and ignores the quotient.
    always_ff @(posedge aclk) begin
        if (en) begin
            div_reg[0]  <= {1'b0, root_fix};
            rem_reg[0]  <= W'(in_adot);
            quo_reg[0]  <= '0;
            side_reg[0] <= {in_side.zero, in_side.neg,
                            in_side.sat || (W'(in_adot) >= W'(root_fix))};
        end
    end

    for (genvar k = 0; k < F; k++) begin : g_step
        logic [W-1:0] sh;
        assign sh = {rem_reg[k][W-2:0], 1'b0};
        always_ff @(posedge aclk) begin
            if (en) begin
                div_reg[k+1]  <= div_reg[k];
                side_reg[k+1] <= side_reg[k];
                if (sh >= div_reg[k]) begin
                    rem_reg[k+1] <= sh - div_reg[k];
                    quo_reg[k+1] <= {quo_reg[k][F-2:0], 1'b1};
                end else begin
                    rem_reg[k+1] <= sh;
                    quo_reg[k+1] <= {quo_reg[k][F-2:0], 1'b0};
                end
            end
        end
    end

    logic [CW-1:0] mag;
    always_comb begin
        if (side_reg[F].sat) begin
            mag = CW'(1) << F;
        end else begin
            mag = CW'(quo_reg[F]);
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            zero_reg <= side_reg[F].zero;
            if (side_reg[F].zero) begin
                cos_reg <= '0;
            end else if (side_reg[F].neg) begin
                cos_reg <= CW'(0) - mag;
            end else begin
                cos_reg <= mag;
            end
        end
    end

    assign out_valid = valid_reg[F+1];
    assign out_cos   = cos_reg;
    assign out_zero  = zero_reg;
endmodule
`default_nettype wire

// ----- rtl/vec2_cosine_unit.sv -----
// vec2_cosine_unit: cosine of the angle between two signed 2D vectors.
// Slave channel s_axis_*: tdata carries a_x, a_y, b_x, b_y (16 bits each,
// a_x lowest). Master channel m_axis_*: tdata carries cosine in Q2.14 (16
// bits), tuser carries zero_vector.
// The block is a fully pipelined datapath: unless the output stalls, an input
// transfer is taken every cycle and one result leaves per cycle. There are 53
// register stages: 3 for products, sums and P*Q, 34 in the root (an input
// register and one root bit per stage for 33 bits) and 16 in the divider (an
// input register, 14 quotient bits and the output register). When a result
// waits with m_axis_tready low the whole pipeline holds, and s_axis_tready is
// low for as long as that stall lasts; nothing is lost or repeated. aresetn
// (synchronous, active low) clears all valid bits; the data registers are not
// reset.
`default_nettype none
module vec2_cosine_unit (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // a_x [15:0], a_y [31:16], b_x [47:32], b_y [63:48]
    input  wire logic [v2cos_pkg::DIN_WIDTH-1:0]    s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // cosine [15:0]
    output logic [v2cos_pkg::DOUT_WIDTH-1:0]        m_axis_tdata,
    // zero_vector [0]
    output logic                                    m_axis_tuser
);
    localparam int C  = v2cos_pkg::COMP_WIDTH;
    localparam int SW = v2cos_pkg::SQ_WIDTH;
    localparam int DW = v2cos_pkg::DOT_WIDTH;

    logic en;
    assign en            = m_axis_tready || !m_axis_tvalid;
    assign s_axis_tready = en;

    logic in_fire;
    assign in_fire = s_axis_tvalid && en;

    // Stage 1: six products of the components.
    logic [2:0] valid_reg;
    logic signed [2*C-1:0] axx_reg, ayy_reg, bxx_reg, byy_reg, xx_reg, yy_reg;
    // Stage 2: sums.
    logic [SW-1:0] p_reg, q_reg;
    logic signed [DW-1:0] dot_reg;
    // Stage 3: P*Q and magnitude of the dot product.
    logic [v2cos_pkg::PQ_WIDTH-1:0] pq_reg;
    logic [DW-1:0] adot_reg;
    v2cos_pkg::side_t side_reg;

    logic signed [C-1:0] ax, ay, bx, by;
    assign ax = s_axis_tdata[C-1:0];
    assign ay = s_axis_tdata[2*C-1:C];
    assign bx = s_axis_tdata[3*C-1:2*C];
    assign by = s_axis_tdata[4*C-1:3*C];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (en) begin
            valid_reg <= {valid_reg[1:0], in_fire};
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            axx_reg <= ax * ax;
            ayy_reg <= ay * ay;
            bxx_reg <= bx * bx;
            byy_reg <= by * by;
            xx_reg  <= ax * bx;
            yy_reg  <= ay * by;
            p_reg   <= SW'(unsigned'(axx_reg)) + SW'(unsigned'(ayy_reg));
            q_reg   <= SW'(unsigned'(bxx_reg)) + SW'(unsigned'(byy_reg));
            dot_reg <= DW'(xx_reg) + DW'(yy_reg);
            pq_reg  <= v2cos_pkg::PQ_WIDTH'(p_reg) * v2cos_pkg::PQ_WIDTH'(q_reg);
            adot_reg <= dot_reg[DW-1] ? DW'(-dot_reg) : DW'(dot_reg);
            side_reg.zero <= (p_reg == '0) || (q_reg == '0);
            side_reg.neg  <= dot_reg[DW-1];
            side_reg.sat  <= 1'b0;
        end
    end

    logic sq_valid;
    logic [v2cos_pkg::ROOT_WIDTH-1:0] sq_root;
    logic [DW-1:0] sq_adot;
    v2cos_pkg::side_t sq_side;

    v2cos_sqrt u_sqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (valid_reg[2]),
        .in_rad    (pq_reg),
        .in_adot   (adot_reg),
        .in_side   (side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_adot  (sq_adot),
        .out_side  (sq_side)
    );

    logic [v2cos_pkg::COS_WIDTH-1:0] cos;
    logic zero;

    v2cos_div u_div (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .en        (en),
        .in_valid  (sq_valid),
        .in_root   (sq_root),
        .in_adot   (sq_adot),
        .in_side   (sq_side),
        .out_valid (m_axis_tvalid),
        .out_cos   (cos),
        .out_zero  (zero)
    );

    assign m_axis_tdata = v2cos_pkg::DOUT_WIDTH'(cos);
    assign m_axis_tuser = zero;
endmodule
`default_nettype wire

// ----- rtl/v2cos_checker.sv -----
`default_nettype none
`include "assert_macros.svh"
module v2cos_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        s_axis_tready,
    input wire logic        m_axis_tvalid,
    input wire logic        m_axis_tready,
    input wire logic [15:0] m_axis_tdata,
    input wire logic        m_axis_tuser
);
    `ASSERT_CLK(a_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ASSERT_CLK(a_zero, aclk, aresetn, m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == 16'd0, "zero vector with nonzero cosine")
    `ASSERT_CLK(a_range, aclk, aresetn, m_axis_tvalid |-> $signed(m_axis_tdata) <= 16'sd16384 && $signed(m_axis_tdata) >= -16'sd16384, "cosine out of range")
    `ASSERT_CLK(a_ready, aclk, aresetn, m_axis_tvalid && !m_axis_tready |-> !s_axis_tready, "input taken while output stalls")
endmodule
bind vec2_cosine_unit v2cos_checker u_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);
`default_nettype wire

// ----- tb/sv/tb.sv -----
`default_nettype none
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY = 52;

    typedef struct packed {
        logic signed [v2cos_pkg::COMP_WIDTH-1:0] b_y;
        logic signed [v2cos_pkg::COMP_WIDTH-1:0] b_x;
        logic signed [v2cos_pkg::COMP_WIDTH-1:0] a_y;
        logic signed [v2cos_pkg::COMP_WIDTH-1:0] a_x;
    } vec_pair_t;

    typedef struct packed {
        logic [v2cos_pkg::COS_WIDTH-1:0] cosine;
        logic                            zero_vector;
    } cos_result_t;

    logic                             aclk = 1'b0;
    logic                             aresetn = 1'b0;
    logic                             s_axis_tvalid = 1'b0;
    logic                             s_axis_tready;
    logic [v2cos_pkg::DIN_WIDTH-1:0]  s_axis_tdata = '0;
    logic                             m_axis_tvalid;
    logic                             m_axis_tready = 1'b0;
    logic [v2cos_pkg::DOUT_WIDTH-1:0] m_axis_tdata;
    logic                             m_axis_tuser;

    vec2_cosine_unit DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #10 aclk = ~aclk;

    vec_pair_t   pair_queue[$];
    cos_result_t cosine_expected[$];
    int          mismatches = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          hold_off_cycles = 0;
    bit          hold_off_start = 1'b0;
    bit          sender_paused = 1'b0;

    // Integer square root of a value up to 128 bits, one bit at a time.
    function automatic logic [63:0] root_floor(logic [127:0] n);
        logic [63:0]  r;
        logic [63:0]  c;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            c = r | (64'd1 << i);
            if ({64'd0, c} * {64'd0, c} <= n)
                r = c;
        end
        return r;
    endfunction

    function automatic cos_result_t predict_cosine(vec_pair_t v);
        cos_result_t  res;
        logic signed [63:0] ax, ay, bx, by, dot;
        logic [63:0]  p, q, adot, s, quo, rem, lim;
        ax = 64'(v.a_x); ay = 64'(v.a_y); bx = 64'(v.b_x); by = 64'(v.b_y);
        p = ax * ax + ay * ay;
        q = bx * bx + by * by;
        res = '0;
        if (p == 0 || q == 0) begin
            res.zero_vector = 1'b1;
            return res;
        end
        dot = ax * bx + ay * by;
        adot = dot < 0 ? -dot : dot;
        s = root_floor({64'd0, p} * {64'd0, q});
        if (s == 0)
            s = 1;
        lim = 64'd1 << v2cos_pkg::FRAC_BITS;
        if (adot >= s) begin
            quo = lim;
        end else begin
            quo = 0;
            rem = adot;
            for (int i = 0; i < v2cos_pkg::FRAC_BITS; i++) begin
                rem = rem << 1;
                quo = quo << 1;
                if (rem >= s) begin
                    rem = rem - s;
                    quo[0] = 1'b1;
                end
            end
        end
        if (quo > lim)
            quo = lim;
        res.cosine = dot < 0 ? v2cos_pkg::COS_WIDTH'(-quo) : v2cos_pkg::COS_WIDTH'(quo);
        return res;
    endfunction

    function automatic logic [v2cos_pkg::COMP_WIDTH-1:0] rand_comp();
        case ($urandom_range(0, 9))
            0: return 16'h8000;
            1: return 16'h7fff;
            2: return 16'(int'($urandom_range(0, 6)) - 3);
            3: return '0;
            default: return v2cos_pkg::COMP_WIDTH'($urandom());
        endcase
    endfunction

    // Driver: presents the next pending item, honoring the sender idle rate.
    always @(negedge aclk) begin
        if (aresetn) begin
            if (!s_axis_tvalid || s_axis_tready) begin
                if (s_axis_tvalid && s_axis_tready)
                    void'(pair_queue.pop_front());
                if (pair_queue.size() > 0 && !sender_paused &&
                    $urandom_range(1, 100) > send_idle_pct) begin
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= pair_queue[0];
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // The expected result is recorded when the transfer is accepted.
    always @(posedge aclk) begin
        if (aresetn && s_axis_tvalid && s_axis_tready)
            cosine_expected.push_back(predict_cosine(s_axis_tdata));
    end

    // Receiver: random stalls, plus a long hold-off counted here.
    always @(negedge aclk) begin
        if (hold_off_start) begin
            hold_off_cycles <= 150;
            m_axis_tready   <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles <= hold_off_cycles - 1;
            m_axis_tready   <= 1'b0;
        end else begin
            m_axis_tready <= $urandom_range(1, 100) > recv_stall_pct;
        end
    end

    // Monitor: compares each result transfer with the oldest expectation.
    always @(posedge aclk) begin
        cos_result_t got, want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            got.cosine      = m_axis_tdata[v2cos_pkg::COS_WIDTH-1:0];
            got.zero_vector = m_axis_tuser;
            if (cosine_expected.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result: cosine %0d zero %0b",
                             $signed(got.cosine), got.zero_vector);
            end else begin
                want = cosine_expected.pop_front();
                if (got !== want) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: cosine exp %0d got %0d, zero exp %0b got %0b",
                                 $signed(want.cosine), $signed(got.cosine),
                                 want.zero_vector, got.zero_vector);
                end
            end
        end
    end

    task automatic drain();
        while (pair_queue.size() > 0 || s_axis_tvalid || cosine_expected.size() > 0)
            @(posedge aclk);
    endtask

    task automatic queue_random(int count);
        vec_pair_t v;
        for (int i = 0; i < count; i++) begin
            v.a_x = rand_comp(); v.a_y = rand_comp();
            v.b_x = rand_comp(); v.b_y = rand_comp();
            pair_queue.push_back(v);
        end
    endtask

    function automatic vec_pair_t mk(int ax, int ay, int bx, int by);
        vec_pair_t v;
        v.a_x = v2cos_pkg::COMP_WIDTH'(ax);
        v.a_y = v2cos_pkg::COMP_WIDTH'(ay);
        v.b_x = v2cos_pkg::COMP_WIDTH'(bx);
        v.b_y = v2cos_pkg::COMP_WIDTH'(by);
        return v;
    endfunction

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: zero vectors, extremes, parallel, opposite, orthogonal.
        pair_queue.push_back(mk(0, 0, 0, 0));
        pair_queue.push_back(mk(0, 0, 5, -7));
        pair_queue.push_back(mk(3, 4, 0, 0));
        pair_queue.push_back(mk(-32768, -32768, -32768, -32768));
        pair_queue.push_back(mk(-32768, -32768, 32767, 32767));
        pair_queue.push_back(mk(32767, 32767, 32767, 32767));
        pair_queue.push_back(mk(-32768, 0, 32767, 0));
        pair_queue.push_back(mk(-32768, 32767, 32767, -32768));
        pair_queue.push_back(mk(1, 0, 0, 1));
        pair_queue.push_back(mk(1, 1, -1, -1));
        pair_queue.push_back(mk(1, 0, 1, 0));
        pair_queue.push_back(mk(3, 4, 4, 3));
        pair_queue.push_back(mk(-1, 0, 0, -32768));
        pair_queue.push_back(mk(32767, 1, 32767, -1));
        pair_queue.push_back(mk(1, 32767, -1, 32767));
        pair_queue.push_back(mk(-21846, 21845, 1, 2));
        drain();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 71; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 71; end
                default: begin send_idle_pct = 7; recv_stall_pct = 7; end
            endcase
            queue_random(400);
            if (phase == 0) begin
                // Long receiver hold-off while the sender keeps offering.
                repeat (20) @(posedge aclk);
                hold_off_start = 1'b1;
                @(posedge aclk);
                hold_off_start = 1'b0;
            end
            if (phase == 3) begin
                repeat (100) @(posedge aclk);
                sender_paused = 1'b1;
                while (s_axis_tvalid || cosine_expected.size() > 0)
                    @(posedge aclk);
                sender_paused = 1'b0;
            end
            drain();
        end

        repeat (LATENCY + 10) @(posedge aclk);
        if (mismatches == 0 && cosine_expected.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial begin
        #2ms;
        $display("tb failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- vec2_cosine_unit.f -----
+incdir+rtl
rtl/v2cos_pkg.sv
rtl/v2cos_sqrt.sv
rtl/v2cos_div.sv
rtl/vec2_cosine_unit.sv
rtl/v2cos_checker.sv
tb/sv/tb.sv
